### sv/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies.
package swm_pkg;

   localparam int DATA_W             = 32;
   localparam int CFG_W              = 7;
   localparam int CFG_RESET          = 3;
   localparam int DEFAULT_MAX_WINDOW = 64;

   // Status a cell shows its neighbors: holds a value above the new sample,
   // and sits at or after the slot being retired.
   typedef struct packed {
      logic gt;
      logic shift;
   } swm_link_type;

endpackage

### sv/swm_cell.sv
// One slot of the sorted window: value and age, updated from its own and its
// neighbors' contents on each request. Depends on swm_pkg.
module swm_cell
   import swm_pkg::*;
#(
   parameter int AGE_W = 6
) (
   input  logic                     clock,
   input  logic                     step,
   input  logic                     valid,
   input  logic                     full,
   input  logic [AGE_W-1:0]         last_age,
   input  logic signed [DATA_W-1:0] new_value,
   input  logic signed [DATA_W-1:0] old_value,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic [AGE_W-1:0]         left_age,
   input  swm_link_type             left_link,
   input  logic signed [DATA_W-1:0] right_value,
   input  logic [AGE_W-1:0]         right_age,
   input  swm_link_type             right_link,
   output logic signed [DATA_W-1:0] value,
   output logic [AGE_W-1:0]         age,
   output swm_link_type             link
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]         age_ff, age_in;
   logic                     retire, after;
   logic                     here_gt, prev_gt;
   logic signed [DATA_W-1:0] here_value, prev_value;
   logic [AGE_W-1:0]         here_age, prev_age;

   always_comb begin
      retire = full && valid && (age_ff == last_age);
      after  = full && (!valid || (value_ff > old_value)
                        || ((value_ff == old_value) && (age_ff != last_age)));
      link.gt    = !valid || (value_ff > new_value);
      link.shift = retire || after;

      // contents of this slot and the previous one once the retired entry is gone
      here_gt    = link.shift ? right_link.gt : link.gt;
      here_value = link.shift ? right_value : value_ff;
      here_age   = link.shift ? right_age : age_ff;
      prev_gt    = left_link.shift ? link.gt : left_link.gt;
      prev_value = left_link.shift ? value_ff : left_value;
      prev_age   = left_link.shift ? age_ff : left_age;

      if (prev_gt) begin
         value_in = prev_value;
         age_in   = prev_age + AGE_W'(1);
      end else if (here_gt) begin
         value_in = new_value;
         age_in   = '0;
      end else begin
         value_in = here_value;
         age_in   = here_age + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

### sv/swm_history.sv
// Arrival-order ring of samples with a registered, write-through read that
// prefetches the sample to retire next. Depends on swm_pkg.
module swm_history
   import swm_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sliding_window_median.sv
// Running median filter over the last window_size signed samples.
// Uses swm_pkg, swm_cell and swm_history.
//
// Takes one sample request per clock cycle while req_ready is high. A row
// of MAX_WINDOW cells keeps the window sorted; on each request every cell
// compares its value with the entering sample and with the retiring one
// (prefetched from the arrival ring) and moves one slot left, right or takes
// the new sample, all in that cycle. Once window_size samples have arrived,
// each request yields the lower median: the row settles at the accepting
// edge, and the middle cell is then selected into the output register. A
// stalled result holds one more finished median inside; beyond that requests
// wait. Writing window_size (0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW) restarts filling.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_median
);

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int RESET_W = (CFG_RESET > MAX_WINDOW) ? MAX_WINDOW : CFG_RESET;

   logic [CNT_W-1:0]         size_ff, size_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         wpos_ff, wpos_in;
   logic                     pend_ff, pend_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] median_ff;

   logic                     step, full, out_load;
   logic [CNT_W-1:0]         size_m1, wpos_inc;
   logic [IDX_W-1:0]         last_age, mid;
   logic signed [DATA_W-1:0] old_value;

   logic signed [DATA_W-1:0] cell_value [MAX_WINDOW];
   logic [IDX_W-1:0]         cell_age   [MAX_WINDOW];
   swm_link_type             cell_link  [MAX_WINDOW];

   assign full      = (fill_ff == size_ff);
   assign out_load  = pend_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || out_load;
   assign step      = req_valid && req_ready;
   assign size_m1   = size_ff - CNT_W'(1);
   assign last_age  = IDX_W'(size_m1);
   assign mid       = IDX_W'(size_m1 >> 1);
   assign wpos_inc  = CNT_W'(wpos_ff) + CNT_W'(1);

   always_comb begin
      size_in = size_ff;
      fill_in = fill_ff;
      wpos_in = wpos_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            size_in = CNT_W'(1);
         end else if (int'(csr_wr_data) > MAX_WINDOW) begin
            size_in = CNT_W'(MAX_WINDOW);
         end else begin
            size_in = CNT_W'(csr_wr_data);
         end
         fill_in = '0;
         wpos_in = '0;
      end else if (step) begin
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         wpos_in = (wpos_inc == size_ff) ? '0 : IDX_W'(wpos_inc);
      end

      // the request that completes the window also yields a median
      pend_in = pend_ff;
      if (step && (full || ((fill_ff + CNT_W'(1)) == size_ff))) begin
         pend_in = 1'b1;
      end else if (out_load) begin
         pend_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CNT_W'(RESET_W);
         fill_ff      <= '0;
         wpos_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         wpos_ff      <= wpos_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         median_ff <= cell_value[mid];
      end
   end

   swm_history #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (IDX_W)
   ) u_history (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (wpos_ff),
      .wr_data (req_sample),
      .rd_addr (wpos_in),
      .rd_data (old_value)
   );

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [DATA_W-1:0] l_value, r_value;
      logic [IDX_W-1:0]         l_age, r_age;
      swm_link_type             l_link, r_link;

      if (i == 0) begin : g_first
         assign l_value = '0;
         assign l_age   = '0;
         assign l_link  = '{gt: 1'b0, shift: 1'b0};
      end else begin : g_mid_l
         assign l_value = cell_value[i-1];
         assign l_age   = cell_age[i-1];
         assign l_link  = cell_link[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign r_value = '0;
         assign r_age   = '0;
         assign r_link  = '{gt: 1'b1, shift: 1'b1};
      end else begin : g_mid_r
         assign r_value = cell_value[i+1];
         assign r_age   = cell_age[i+1];
         assign r_link  = cell_link[i+1];
      end

      swm_cell #(
         .AGE_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .step        (step),
         .valid       (CNT_W'(i) < fill_ff),
         .full        (full),
         .last_age    (last_age),
         .new_value   (req_sample),
         .old_value   (old_value),
         .left_value  (l_value),
         .left_age    (l_age),
         .left_link   (l_link),
         .right_value (r_value),
         .right_age   (r_age),
         .right_link  (r_link),
         .value       (cell_value[i]),
         .age         (cell_age[i]),
         .link        (cell_link[i])
      );
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_median = median_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_ff)
      else $error("fill count above window size");

   a_full_emits : assert property (@(posedge clock) disable iff (reset)
      step && full |=> pend_ff)
      else $error("full-window request did not queue a median");

   a_cfg_restart : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (fill_ff == '0) && (wpos_ff == '0))
      else $error("window size write did not restart filling");

   a_hold_when_blocked : assert property (@(posedge clock) disable iff (reset)
      pend_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while a median is stuck");

   for (genvar i = 0; i + 1 < MAX_WINDOW; i++) begin : g_chk
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         (CNT_W'(i + 1) < fill_ff) |-> (cell_value[i] <= cell_value[i+1]))
         else $error("sorted row out of order");
   end

endmodule
